// ===== sv/tps_pkg.sv =====
`timescale 1ns / 1ps

package tps_pkg;

    localparam int AMP_W   = 20;
    localparam int QUIET_W = 8;
    localparam int IDX_W   = 14;
    localparam int ORD_W   = 10;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic [QUIET_W-1:0] QUIET_MAX = {QUIET_W{1'b1}};
    localparam logic [ORD_W-1:0]   ORD_MAX   = {ORD_W{1'b1}};
    localparam logic [IDX_W-1:0]   IDX_MAX   = {IDX_W{1'b1}};

    localparam logic signed [AMP_W-1:0] THRESHOLD_RESET = '0;
    localparam logic [QUIET_W-1:0]      QUIET_RESET     = 8'd4;

    // Register select, taken from paddr[2]
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_QUIET     = 1'b1;

    typedef struct packed {
        logic signed [AMP_W-1:0] amplitude_threshold;
        logic [QUIET_W-1:0]      min_quiet_samples;
    } cfg_t;

    typedef struct packed {
        logic                    pulse_valid;
        logic signed [AMP_W-1:0] pulse_peak;
        logic [IDX_W-1:0]        pulse_start;
        logic [ORD_W-1:0]        pulse_ordinal;
        logic                    record_done;
    } result_t;

endpackage

// ===== sv/tps_cfg_regs.sv =====
`timescale 1ns / 1ps

module tps_cfg_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tps_pkg::ADDR_W-1:0]    paddr,
    input  logic [tps_pkg::DATA_W-1:0]    pwdata,
    output logic [tps_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output tps_pkg::cfg_t                 cfg
);

    tps_pkg::cfg_t cfg_reg;
    tps_pkg::cfg_t cfg_next;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                tps_pkg::REG_THRESHOLD:
                    cfg_next.amplitude_threshold = pwdata[tps_pkg::AMP_W-1:0];
                tps_pkg::REG_QUIET:
                    cfg_next.min_quiet_samples = pwdata[tps_pkg::QUIET_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.amplitude_threshold <= tps_pkg::THRESHOLD_RESET;
            cfg_reg.min_quiet_samples   <= tps_pkg::QUIET_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Sign-extend the threshold on read-back
    always_comb
    begin
        unique case (paddr[2])
            tps_pkg::REG_THRESHOLD:
                prdata = {{(tps_pkg::DATA_W-tps_pkg::AMP_W){cfg_reg.amplitude_threshold[tps_pkg::AMP_W-1]}},
                          cfg_reg.amplitude_threshold};
            tps_pkg::REG_QUIET:
                prdata = {{(tps_pkg::DATA_W-tps_pkg::QUIET_W){1'b0}}, cfg_reg.min_quiet_samples};
            default:
                prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/tps_core.sv =====
`timescale 1ns / 1ps

module tps_core
#(
    parameter int MAX_RECORD_SAMPLES = 16384
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  tps_pkg::cfg_t                     cfg,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [tps_pkg::AMP_W-1:0]  sample_amplitude,
    input  logic                              last_sample,
    output logic                              out_valid,
    input  logic                              out_ready,
    output tps_pkg::result_t                  result
);

    localparam logic [tps_pkg::IDX_W-1:0] INDEX_LIMIT =
        (MAX_RECORD_SAMPLES - 1 > int'(tps_pkg::IDX_MAX)) ? tps_pkg::IDX_MAX
                                                          : tps_pkg::IDX_W'(MAX_RECORD_SAMPLES - 1);

    logic                               in_pulse_reg,      in_pulse_next;
    logic [tps_pkg::QUIET_W-1:0]        quiet_count_reg,   quiet_count_next;
    logic signed [tps_pkg::AMP_W-1:0]   running_peak_reg,  running_peak_next;
    logic [tps_pkg::IDX_W-1:0]          start_index_reg,   start_index_next;
    logic [tps_pkg::IDX_W-1:0]          sample_index_reg,  sample_index_next;
    logic [tps_pkg::ORD_W-1:0]          pulse_counter_reg, pulse_counter_next;
    logic                               out_valid_reg,     out_valid_next;
    tps_pkg::result_t                   result_reg,        result_next;

    logic                               accept;
    logic                               elevated;
    logic [tps_pkg::QUIET_W-1:0]        quiet_inc;
    logic                               closed;
    logic                               emit;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign elevated = sample_amplitude > cfg.amplitude_threshold;
    assign quiet_inc = (quiet_count_reg < tps_pkg::QUIET_MAX) ? quiet_count_reg + 1'b1
                                                              : quiet_count_reg;

    always_comb
    begin
        in_pulse_next      = in_pulse_reg;
        quiet_count_next   = quiet_count_reg;
        running_peak_next  = running_peak_reg;
        start_index_next   = start_index_reg;
        sample_index_next  = sample_index_reg;
        pulse_counter_next = pulse_counter_reg;
        closed             = 1'b0;
        result_next        = '0;

        if (elevated)
        begin
            if (!in_pulse_reg)
            begin
                in_pulse_next     = 1'b1;
                running_peak_next = sample_amplitude;
                start_index_next  = sample_index_reg;
            end
            else if (sample_amplitude > running_peak_reg)
            begin
                running_peak_next = sample_amplitude;
            end
            quiet_count_next = '0;
        end
        else if (in_pulse_reg)
        begin
            quiet_count_next = quiet_inc;
            // a quiet setting of zero still needs one quiet sample, since quiet_inc >= 1
            if (quiet_inc >= cfg.min_quiet_samples)
            begin
                closed           = 1'b1;
                in_pulse_next    = 1'b0;
                quiet_count_next = '0;
                if (pulse_counter_reg < tps_pkg::ORD_MAX)
                    pulse_counter_next = pulse_counter_reg + 1'b1;
            end
        end

        // Report the pulse from pre-update counters; an open pulse on the last
        // sample uses the freshly updated peak and start
        if (closed)
        begin
            result_next.pulse_valid   = 1'b1;
            result_next.pulse_peak    = running_peak_reg;
            result_next.pulse_start   = start_index_reg;
            result_next.pulse_ordinal = pulse_counter_reg;
        end
        else if (last_sample && in_pulse_next)
        begin
            result_next.pulse_valid   = 1'b1;
            result_next.pulse_peak    = running_peak_next;
            result_next.pulse_start   = start_index_next;
            result_next.pulse_ordinal = pulse_counter_reg;
        end
        result_next.record_done = last_sample;

        if (last_sample)
        begin
            // clear everything for the next record
            in_pulse_next      = 1'b0;
            quiet_count_next   = '0;
            running_peak_next  = '0;
            start_index_next   = '0;
            sample_index_next  = '0;
            pulse_counter_next = '0;
        end
        else if (sample_index_reg < INDEX_LIMIT)
        begin
            sample_index_next = sample_index_reg + 1'b1;
        end
    end

    assign emit = closed || last_sample;

    always_comb
    begin
        if (accept && emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_pulse_reg      <= 1'b0;
            quiet_count_reg   <= '0;
            running_peak_reg  <= '0;
            start_index_reg   <= '0;
            sample_index_reg  <= '0;
            pulse_counter_reg <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                in_pulse_reg      <= in_pulse_next;
                quiet_count_reg   <= quiet_count_next;
                running_peak_reg  <= running_peak_next;
                start_index_reg   <= start_index_next;
                sample_index_reg  <= sample_index_next;
                pulse_counter_reg <= pulse_counter_next;
            end
        end
    end

    // Result register: load only on a transfer that yields a result
    always_ff @(posedge clk)
    begin
        if (accept && emit)
            result_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

// ===== sv/threshold_pulse_segmenter_top.sv =====
`timescale 1ns / 1ps
// Output: registered; an input transfer's result is in the output register in the cycle after it.
// Throughput: one sample per cycle; the single result register stalls input only
// while a result waits and out_ready is low.
// Reset: rst_n asynchronous, active low; clears pulse state, counters and output
// valid, and loads threshold 0 and quiet count 4.

module threshold_pulse_segmenter_top
#(
    parameter int MAX_RECORD_SAMPLES = 16384
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tps_pkg::ADDR_W-1:0]        paddr,
    input  logic [tps_pkg::DATA_W-1:0]        pwdata,
    output logic [tps_pkg::DATA_W-1:0]        prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [tps_pkg::AMP_W-1:0]  sample_amplitude,
    input  logic                              last_sample,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              pulse_valid,
    output logic signed [tps_pkg::AMP_W-1:0]  pulse_peak,
    output logic [tps_pkg::IDX_W-1:0]         pulse_start,
    output logic [tps_pkg::ORD_W-1:0]         pulse_ordinal,
    output logic                              record_done
);

    tps_pkg::cfg_t    cfg;
    tps_pkg::result_t result;

    tps_cfg_regs u_cfg_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tps_core
    #(
        .MAX_RECORD_SAMPLES (MAX_RECORD_SAMPLES)
    )
    u_core
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .sample_amplitude (sample_amplitude),
        .last_sample      (last_sample),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .result           (result)
    );

    assign pulse_valid   = result.pulse_valid;
    assign pulse_peak    = result.pulse_peak;
    assign pulse_start   = result.pulse_start;
    assign pulse_ordinal = result.pulse_ordinal;
    assign record_done   = result.record_done;

`ifndef ASSERT_OFF
    // The last sample of a record always yields a record-done result
    a_last_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last_sample |=> out_valid && record_done)
        else $error("last sample did not produce a record-done result");

    // A result is either a pulse report or the end of a record
    a_no_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pulse_valid || record_done))
        else $error("result with neither pulse nor record done");

    // A record-done result with no pulse carries zero fields
    a_done_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && record_done && !pulse_valid |->
            (pulse_peak == '0) && (pulse_start == '0) && (pulse_ordinal == '0))
        else $error("record-done result without pulse has non-zero fields");
`endif

endmodule
